/* sv/lzwr_pkg.sv */
`timescale 1ns / 1ps
package lzwr_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int HIST_AW = $clog2(WINDOW_SIZE);
	localparam int BURST = 64;
	localparam int BURST_W = $clog2(BURST + 1);
	localparam int COUNT_W = 31;
	localparam int RUN_W = 9;
	localparam int FLAG_CNT_W = 4;

	localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_CODE = 4'd8;
	localparam logic [RUN_W-1:0] LEN_SHORT_BIAS = 9'd2;
	localparam logic [RUN_W-1:0] LEN_LONG_BIAS = 9'h12;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_BADDIST = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_CODE,
		PH_ITEM,
		PH_REF2,
		PH_REF3,
		PH_RUN
	} phase_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EVAL,
		FSM_READ,
		FSM_EMIT
	} fsm_t;

	typedef enum logic {
		CMD_BYTE     = 1'b0,
		CMD_CONTINUE = 1'b1
	} command_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last_of_run;
		logic       finished;
	} result_t;

endpackage

/* sv/lz_window_run_decompressor.sv */
`timescale 1ns / 1ps
// Yaz0 stream decompressor taking one compressed byte per item. An item is registered when
// taken and decoded from those registers once the output slot is free. A back-reference
// run then copies through the single-port 4096-byte history RAM byte by byte (FSM_READ reads
// the source, FSM_EMIT writes the byte back and presents it once the output slot is free),
// up to 64 bytes per item. Input stall stays high from acceptance until the item is done
// with: its last result loaded into the output register or, for an item that yields no
// result, its decode finished. Write output_size before the stream starts: after reset
// it is zero, so every item is answered with an already-finished status.
module lz_window_run_decompressor (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [30:0]              cfg_wdata,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  lzwr_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output lzwr_pkg::result_t        result
);

	import lzwr_pkg::*;

	fsm_t                   fsm_q, fsm_d;
	phase_t                 phase_q, phase_d;
	logic                   cmd_q;
	logic [7:0]             byte_q;
	logic [7:0]             flags_q, flags_d;
	logic [FLAG_CNT_W-1:0]  flags_left_q, flags_left_d;
	logic [7:0]             ref1_q, ref1_d;
	logic [HIST_AW-1:0]     dist_q, dist_d;
	logic [RUN_W-1:0]       run_q, run_d;
	logic [HIST_AW-1:0]     wp_q, wp_d;
	logic [COUNT_W-1:0]     produced_q, produced_d;
	logic [COUNT_W-1:0]     output_size_q;
	logic [BURST_W-1:0]     burst_q, burst_d;
	result_t                result_q, result_d;
	logic                   result_valid_q;
	logic                   push;

	logic                   out_free;
	logic                   finished_now;
	logic [COUNT_W-1:0]     produced_inc;
	logic                   finished_inc;
	logic [HIST_AW-1:0]     dist_ref2;
	logic [HIST_AW-1:0]     dist_sel;
	logic                   bad_dist;
	logic [RUN_W-1:0]       run_dec;
	logic [FLAG_CNT_W-1:0]  flags_left_dec;
	logic                   emit_last;

	logic                   ram_we;
	logic                   ram_re;
	logic [HIST_AW-1:0]     ram_addr;
	logic [7:0]             ram_wdata;
	logic [7:0]             ram_rdata;

	lzwr_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_history (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign out_free       = !result_valid_q || !result_stall;
	assign finished_now   = produced_q >= output_size_q;
	assign produced_inc   = produced_q + COUNT_W'(1);
	assign finished_inc   = produced_inc >= output_size_q;
	assign dist_ref2      = {ref1_q[3:0], byte_q};
	assign dist_sel       = (phase_q == PH_REF2) ? dist_ref2 : dist_q;
	// The reference reaches dist + 1 bytes back, so it needs more than dist bytes produced.
	assign bad_dist       = COUNT_W'(dist_sel) >= produced_q;
	assign run_dec        = run_q - RUN_W'(1);
	assign flags_left_dec = flags_left_q - FLAG_CNT_W'(1);
	assign emit_last      = (burst_q == BURST_W'(BURST - 1)) || (run_dec == '0) || finished_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q          <= FSM_IDLE;
			phase_q        <= PH_CODE;
			flags_q        <= '0;
			flags_left_q   <= '0;
			ref1_q         <= '0;
			dist_q         <= '0;
			run_q          <= '0;
			wp_q           <= '0;
			produced_q     <= '0;
			output_size_q  <= '0;
			burst_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			fsm_q        <= fsm_d;
			phase_q      <= phase_d;
			flags_q      <= flags_d;
			flags_left_q <= flags_left_d;
			ref1_q       <= ref1_d;
			dist_q       <= dist_d;
			run_q        <= run_d;
			wp_q         <= wp_d;
			produced_q   <= produced_d;
			burst_q      <= burst_d;
			if (cfg_we) begin
				output_size_q <= cfg_wdata;
			end
			if (push) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_q  <= item.command;
			byte_q <= item.data_byte;
		end
		if (push) begin
			result_q <= result_d;
		end
	end

	always_comb begin
		fsm_d        = fsm_q;
		phase_d      = phase_q;
		flags_d      = flags_q;
		flags_left_d = flags_left_q;
		ref1_d       = ref1_q;
		dist_d       = dist_q;
		run_d        = run_q;
		wp_d         = wp_q;
		produced_d   = produced_q;
		burst_d      = burst_q;
		push         = 1'b0;
		result_d     = '{out_byte: 8'd0, status: ST_OK, last_of_run: 1'b1,
			finished: finished_now};
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_addr     = wp_q;
		ram_wdata    = byte_q;

		unique case (fsm_q)
			FSM_IDLE: begin
				if (item_valid) begin
					fsm_d = FSM_EVAL;
				end
			end

			FSM_EVAL: begin
				// Every decision waits for a free output slot, so nothing commits twice.
				if (out_free) begin
					fsm_d = FSM_IDLE;
					if (finished_now) begin
						push            = 1'b1;
						result_d.status = ST_DONE;
					end else if (cmd_q == CMD_CONTINUE) begin
						if (phase_q == PH_RUN) begin
							burst_d = '0;
							fsm_d   = FSM_READ;
						end
					end else begin
						unique case (phase_q)
							PH_CODE: begin
								flags_d      = byte_q;
								flags_left_d = FLAGS_PER_CODE;
								phase_d      = PH_ITEM;
							end
							PH_ITEM: begin
								if (flags_q[7]) begin
									ram_we               = 1'b1;
									wp_d                 = wp_q + HIST_AW'(1);
									produced_d           = produced_inc;
									flags_d              = {flags_q[6:0], 1'b0};
									flags_left_d         = flags_left_dec;
									phase_d              = (flags_left_dec == '0) ? PH_CODE
										: PH_ITEM;
									push                 = 1'b1;
									result_d.out_byte    = byte_q;
									result_d.finished    = finished_inc;
								end else begin
									ref1_d  = byte_q;
									phase_d = PH_REF2;
								end
							end
							PH_REF2, PH_REF3: begin
								dist_d = dist_sel;
								if (phase_q == PH_REF2 && ref1_q[7:4] == 4'd0) begin
									phase_d = PH_REF3;
								end else if (bad_dist) begin
									run_d           = '0;
									flags_d         = {flags_q[6:0], 1'b0};
									flags_left_d    = flags_left_dec;
									phase_d         = (flags_left_dec == '0) ? PH_CODE
										: PH_ITEM;
									push            = 1'b1;
									result_d.status = ST_BADDIST;
								end else begin
									run_d   = (phase_q == PH_REF2)
										? RUN_W'(ref1_q[7:4]) + LEN_SHORT_BIAS
										: RUN_W'(byte_q) + LEN_LONG_BIAS;
									burst_d = '0;
									fsm_d   = FSM_READ;
								end
							end
							PH_RUN: begin
								push            = 1'b1;
								result_d.status = ST_BUSY;
							end
							default: begin
								phase_d = PH_CODE;
							end
						endcase
					end
				end
			end

			FSM_READ: begin
				ram_re   = 1'b1;
				ram_addr = wp_q - dist_q - HIST_AW'(1);
				fsm_d    = FSM_EMIT;
			end

			FSM_EMIT: begin
				ram_wdata = ram_rdata;
				if (out_free) begin
					ram_we               = 1'b1;
					wp_d                 = wp_q + HIST_AW'(1);
					produced_d           = produced_inc;
					run_d                = finished_inc ? '0 : run_dec;
					burst_d              = burst_q + BURST_W'(1);
					push                 = 1'b1;
					result_d.out_byte    = ram_rdata;
					result_d.last_of_run = emit_last;
					result_d.finished    = finished_inc;
					if (emit_last) begin
						fsm_d = FSM_IDLE;
						if (finished_inc || run_dec == '0) begin
							flags_d      = {flags_q[6:0], 1'b0};
							flags_left_d = flags_left_dec;
							phase_d      = (flags_left_dec == '0) ? PH_CODE : PH_ITEM;
						end else begin
							phase_d = PH_RUN;
						end
					end else begin
						fsm_d = FSM_READ;
					end
				end
			end

			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	assign item_stall   = (fsm_q != FSM_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_copy_advances_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == FSM_EMIT && out_free) |=> produced_q == $past(produced_inc))
		else $error("copied byte did not advance the output count");

	a_run_pending_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RUN) |-> run_q != '0)
		else $error("pending run phase with nothing left to copy");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == FSM_EMIT) |-> (run_q != '0 && !finished_now))
		else $error("copy step entered with an empty run or after finishing");
`endif

endmodule

/* sv/lzwr_ram.sv */
`timescale 1ns / 1ps
module lzwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
